>>> rtl/core/aalu_pkg.sv
package aalu_pkg;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_ADC = 3'd1,
		OP_SUB = 3'd2,
		OP_SBC = 3'd3,
		OP_XOR = 3'd4,
		OP_OR  = 3'd5,
		OP_CP  = 3'd6
	} alu_op_t;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	localparam logic [7:0] ACC_START_MONO   = 8'h01;
	localparam logic [7:0] ACC_START_COLOR  = 8'h11;
	localparam flags_t     FLAGS_START_MONO  = '{z: 1'b1, n: 1'b0, h: 1'b1, c: 1'b1};
	localparam flags_t     FLAGS_START_COLOR = '{z: 1'b1, n: 1'b0, h: 1'b0, c: 1'b0};

endpackage

>>> rtl/core/accumulator_alu_with_flags.sv
// 8-bit accumulator ALU with Z/N/H/C flags.
// Input channel: in_valid/in_stall with op_select and operand. A transaction
// is taken on a clock edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall with acc_out and the four flags, which
// show the accumulator and flags after the operation.
// A taken transaction is held in the input register, then its result is
// written to the accumulator and flag registers. Throughput: one transaction
// per cycle while out_stall is low; accumulator and flag registers feed the
// ALU directly, so each operation sees the result of the one just before it.
// While out_stall holds a result, the input register keeps one more
// transaction and then raises in_stall; nothing is dropped.
// Reset: model_mode goes to 0 (monochrome), the accumulator to 0x01 and the
// flags to Z H C. Writing cfg_wr_en/cfg_wr_data sets model_mode and reloads
// the accumulator and flags with the start values of that mode (0x11, Z only
// for the color model). Write it only while no transaction is in flight.
module accumulator_alu_with_flags (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] op_select,
	input  logic [7:0] operand,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] acc_out,
	output logic       zero_flag,
	output logic       sub_flag,
	output logic       half_flag,
	output logic       carry_flag
);
	import aalu_pkg::*;

	logic       valid_s1;
	logic [2:0] op_s1;
	logic [7:0] operand_s1;
	logic       advance;
	logic       mode_q;
	logic [7:0] acc_q;
	flags_t     flags_q;
	logic [7:0] acc_next;
	flags_t     flags_next;
	logic       out_valid_q;

	assign advance = valid_s1 & (~out_valid_q | ~out_stall);

	aalu_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op_select  (op_select),
		.operand    (operand),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.op_s1      (op_s1),
		.operand_s1 (operand_s1)
	);

	aalu_exec u_exec (
		.op         (op_s1),
		.operand    (operand_s1),
		.acc        (acc_q),
		.flags      (flags_q),
		.acc_next   (acc_next),
		.flags_next (flags_next)
	);

	// accumulator and flags double as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			acc_q   <= ACC_START_MONO;
			flags_q <= FLAGS_START_MONO;
		end else if (cfg_wr_en) begin
			mode_q  <= cfg_wr_data;
			acc_q   <= cfg_wr_data ? ACC_START_COLOR : ACC_START_MONO;
			flags_q <= cfg_wr_data ? FLAGS_START_COLOR : FLAGS_START_MONO;
		end else if (advance) begin
			acc_q   <= acc_next;
			flags_q <= flags_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign acc_out    = acc_q;
	assign zero_flag  = flags_q.z;
	assign sub_flag   = flags_q.n;
	assign half_flag  = flags_q.h;
	assign carry_flag = flags_q.c;

`ifndef NO_ASSERTIONS
	a_stall_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

	a_cfg_reload: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (mode_q == $past(cfg_wr_data)) &&
			(acc_q == (mode_q ? ACC_START_COLOR : ACC_START_MONO)))
		else $error("mode write did not reload accumulator");

	a_cp_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg_wr_en && op_s1 == OP_CP) |=> (acc_q == $past(acc_q)) && flags_q.n)
		else $error("compare changed accumulator");

	a_logic_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg_wr_en && (op_s1 == OP_XOR || op_s1 == OP_OR))
		|=> !flags_q.n && !flags_q.h && !flags_q.c)
		else $error("logic op left N/H/C set");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result without a transaction in the stage");
`endif

endmodule

>>> rtl/core/aalu_in_stage.sv
module aalu_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] op_select,
	input  logic [7:0] operand,
	input  logic       advance,
	output logic       valid_s1,
	output logic [2:0] op_s1,
	output logic [7:0] operand_s1
);
	import aalu_pkg::*;

	logic load;

	// stage frees up in the same cycle it hands its transaction on
	assign in_stall = valid_s1 & ~advance;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_s1      <= op_select;
			operand_s1 <= operand;
		end
	end

endmodule

>>> rtl/core/aalu_exec.sv
module aalu_exec (
	input  logic            [2:0] op,
	input  logic            [7:0] operand,
	input  logic            [7:0] acc,
	input  aalu_pkg::flags_t      flags,
	output logic            [7:0] acc_next,
	output aalu_pkg::flags_t      flags_next
);
	import aalu_pkg::*;

	logic       k_add;
	logic       k_sub;
	logic [8:0] sum;
	logic [4:0] sum_lo;
	logic [8:0] diff;
	logic [4:0] diff_lo;
	logic [7:0] x_res;
	logic [7:0] o_res;

	assign k_add = (op == OP_ADC) & flags.c;
	assign k_sub = (op == OP_SBC) & flags.c;

	assign sum     = {1'b0, acc} + {1'b0, operand} + {8'd0, k_add};
	assign sum_lo  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, k_add};
	// bit 8 / bit 4 of the wrapped difference is the borrow
	assign diff    = {1'b0, acc} - {1'b0, operand} - {8'd0, k_sub};
	assign diff_lo = {1'b0, acc[3:0]} - {1'b0, operand[3:0]} - {4'd0, k_sub};
	assign x_res   = acc ^ operand;
	assign o_res   = acc | operand;

	always_comb begin
		acc_next   = acc;
		flags_next = flags;
		case (op)
			OP_ADD, OP_ADC: begin
				acc_next   = sum[7:0];
				flags_next = '{z: (sum[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum[8]};
			end
			OP_SUB, OP_SBC: begin
				acc_next   = diff[7:0];
				flags_next = '{z: (diff[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff[8]};
			end
			OP_CP: begin
				flags_next = '{z: (diff[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff[8]};
			end
			OP_XOR: begin
				acc_next   = x_res;
				flags_next = '{z: (x_res == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			OP_OR: begin
				acc_next   = o_res;
				flags_next = '{z: (o_res == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
			end
			default: begin
				acc_next   = acc;
				flags_next = flags;
			end
		endcase
	end

endmodule
